// ----- src/byterun1_bitplane_unpacker_macros.svh -----
// Assertion macros for the bitplane unpacker checks.
// Each expects clk and rst_n in scope.
`ifndef BYTERUN1_BITPLANE_UNPACKER_MACROS_SVH
`define BYTERUN1_BITPLANE_UNPACKER_MACROS_SVH

// Same-cycle implication.
`define BRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bru_pkg.sv -----
package bru_pkg;

    // Default limits
    localparam int MAX_ROW_BYTES_DEF = 256;
    localparam int MAX_PLANES_DEF    = 32;
    localparam int MAX_ROWS_DEF      = 4096;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_BYTES    = 3'd0,
        REG_PLANE_COUNT  = 3'd1,
        REG_MASK_PRESENT = 3'd2,
        REG_COMPRESSED   = 3'd3,
        REG_ROW_COUNT    = 3'd4
    } bru_reg_t;

    // Control byte that does nothing
    localparam logic [7:0] NOP_CTRL = 8'h80;

    typedef struct packed {
        logic [8:0]  row_bytes;
        logic [5:0]  plane_count;
        logic        mask_present;
        logic        compressed;
        logic [12:0] row_count;
    } bru_cfg_t;

    localparam bru_cfg_t CFG_RESET = '{
        row_bytes:    9'd40,
        plane_count:  6'd5,
        mask_present: 1'b0,
        compressed:   1'b1,
        row_count:    13'd200
    };

    typedef struct packed {
        logic [7:0] body_byte;
        logic       first;
    } bru_body_t;

    typedef struct packed {
        logic [4:0]  plane;
        logic [11:0] row;
        logic [7:0]  column;
        logic [7:0]  value;
        logic [7:0]  count;
        logic        clipped;
    } bru_rec_t;

endpackage

// ----- src/bru_cfg.sv -----
module bru_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bru_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bru_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bru_pkg::bru_cfg_t                 cfg
);

    bru_pkg::bru_cfg_t cfg_reg;
    bru_pkg::bru_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bru_pkg::REG_ROW_BYTES:    cfg_next.row_bytes    = cfg_data[8:0];
                bru_pkg::REG_PLANE_COUNT:  cfg_next.plane_count  = cfg_data[5:0];
                bru_pkg::REG_MASK_PRESENT: cfg_next.mask_present = cfg_data[0];
                bru_pkg::REG_COMPRESSED:   cfg_next.compressed   = cfg_data[0];
                bru_pkg::REG_ROW_COUNT:    cfg_next.row_count    = cfg_data[12:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bru_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/bru_core.sv -----
module bru_core #(
    parameter int MAX_ROW_BYTES = bru_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = bru_pkg::MAX_PLANES_DEF,
    parameter int MAX_ROWS      = bru_pkg::MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bru_pkg::bru_body_t body,
    input  bru_pkg::bru_cfg_t  cfg,
    output logic               hit,
    output bru_pkg::bru_rec_t  rec
);

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int PW = $clog2(MAX_PLANES + 1);
    localparam int TW = $clog2(MAX_PLANES + 2);
    localparam int RW = $clog2(MAX_ROWS + 1);

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    phase_t        phase_reg, phase_next, phase_cur;
    logic [7:0]    run_left_reg, run_left_next, run_left_cur;
    logic [7:0]    run_len_reg, run_len_next, run_len_cur;
    logic [PW-1:0] plane_reg, plane_next, plane_cur;
    logic [RW-1:0] row_reg, row_next, row_cur;
    logic [CW-1:0] col_reg, col_next, col_cur;

    logic [CW-1:0] rb;
    logic [PW-1:0] pc;
    logic [RW-1:0] rows;
    logic [TW-1:0] total;
    logic [TW-1:0] plane_inc;
    logic [CW:0]   rb_x, col_x, col_new, avail;
    logic [7:0]    rep_cnt;
    logic          data_plane, col_lt, wrap;
    logic [7:0]    rec_count;
    logic          rec_clip;

    // Effective register values, saturated to the supported range
    always_comb
    begin
        if (cfg.row_bytes == '0)
            rb = CW'(1);
        else if (32'(cfg.row_bytes) > 32'(MAX_ROW_BYTES))
            rb = CW'(MAX_ROW_BYTES);
        else
            rb = CW'(cfg.row_bytes);

        if (cfg.plane_count == '0)
            pc = PW'(1);
        else if (32'(cfg.plane_count) > 32'(MAX_PLANES))
            pc = PW'(MAX_PLANES);
        else
            pc = PW'(cfg.plane_count);

        if (cfg.row_count == '0)
            rows = RW'(1);
        else if (32'(cfg.row_count) > 32'(MAX_ROWS))
            rows = RW'(MAX_ROWS);
        else
            rows = RW'(cfg.row_count);
    end

    assign total = TW'(pc) + TW'(cfg.mask_present);

    // first restarts position before the byte is used
    always_comb
    begin
        if (body.first)
        begin
            phase_cur    = PH_CTRL;
            run_left_cur = '0;
            run_len_cur  = '0;
            plane_cur    = '0;
            row_cur      = '0;
            col_cur      = '0;
        end
        else
        begin
            phase_cur    = phase_reg;
            run_left_cur = run_left_reg;
            run_len_cur  = run_len_reg;
            plane_cur    = plane_reg;
            row_cur      = row_reg;
            col_cur      = col_reg;
        end
    end

    assign rb_x       = {1'b0, rb};
    assign col_x      = {1'b0, col_cur};
    assign col_lt     = col_x < rb_x;
    assign data_plane = TW'(plane_cur) < TW'(pc);
    assign avail      = col_lt ? (rb_x - col_x) : '0;
    assign rep_cnt    = (32'(run_len_cur) < 32'(avail)) ? run_len_cur : 8'(avail);
    assign plane_inc  = TW'(plane_cur) + TW'(1);

    always_comb
    begin
        phase_next    = phase_cur;
        run_left_next = run_left_cur;
        run_len_next  = run_len_cur;
        col_new       = col_x;
        wrap          = 1'b0;
        hit           = 1'b0;
        rec_count     = 8'd1;
        rec_clip      = 1'b0;

        if (row_cur >= rows)
        begin
            // past the last row: ignored
            hit = 1'b0;
        end
        else if (!cfg.compressed)
        begin
            phase_next    = PH_CTRL;
            run_left_next = '0;
            run_len_next  = '0;
            hit           = col_lt && data_plane;
            col_new       = col_x + 1'b1;
            wrap          = col_new >= rb_x;
        end
        else
        begin
            unique case (phase_cur)
                PH_LIT:
                begin
                    if (col_lt)
                    begin
                        hit      = data_plane;
                        rec_clip = (col_x == rb_x - 1'b1) && (run_left_cur > 8'd1);
                        col_new  = col_x + 1'b1;
                    end
                    run_left_next = (run_left_cur != '0) ? run_left_cur - 1'b1 : '0;
                    if (run_left_next == '0)
                    begin
                        phase_next = PH_CTRL;
                        wrap       = col_new >= rb_x;
                    end
                end
                PH_REP:
                begin
                    rec_count    = rep_cnt;
                    rec_clip     = rep_cnt < run_len_cur;
                    hit          = (rep_cnt != '0) && data_plane;
                    col_new      = col_x + (CW+1)'(rep_cnt);
                    phase_next   = PH_CTRL;
                    run_len_next = '0;
                    wrap         = col_new >= rb_x;
                end
                PH_CTRL:
                begin
                    if (!body.body_byte[7])
                    begin
                        run_left_next = body.body_byte + 8'd1;
                        phase_next    = PH_LIT;
                    end
                    else if (body.body_byte != bru_pkg::NOP_CTRL)
                    begin
                        run_len_next = 8'(9'd257 - {1'b0, body.body_byte});
                        phase_next   = PH_REP;
                    end
                end
                default:
                begin
                    phase_next = PH_CTRL;
                end
            endcase
        end
    end

    // Advance to the next plane row when the row end is reached
    always_comb
    begin
        plane_next = plane_cur;
        row_next   = row_cur;
        col_next   = CW'(col_new);
        if (wrap)
        begin
            col_next = '0;
            if (plane_inc >= total)
            begin
                plane_next = '0;
                row_next   = row_cur + 1'b1;
            end
            else
            begin
                plane_next = PW'(plane_inc);
            end
        end
    end

    always_comb
    begin
        rec.plane   = 5'(32'(plane_cur));
        rec.row     = 12'(32'(row_cur));
        rec.column  = 8'(32'(col_cur));
        rec.value   = body.body_byte;
        rec.count   = rec_count;
        rec.clipped = rec_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CTRL;
            run_left_reg <= '0;
            run_len_reg  <= '0;
            plane_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            run_len_reg  <= run_len_next;
            plane_reg    <= plane_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

endmodule

// ----- src/byterun1_bitplane_unpacker.sv -----
// A body byte waits in the input register; bru_core decodes it into the result register.
// Throughput: one body byte per cycle, sustained while records are taken; the position and
//   run counters in bru_core update on every accepted byte, so consecutive bytes need no gap.
// A byte that yields no record still takes one slot in the input register.
// Reset (rst_n low, asynchronous): both pipeline registers empty, decoder expects a control
//   byte at plane 0, row 0, column 0; configuration returns to its defaults.
module byterun1_bitplane_unpacker #(
    parameter int MAX_ROW_BYTES = bru_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = bru_pkg::MAX_PLANES_DEF,
    parameter int MAX_ROWS      = bru_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [bru_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bru_pkg::CFG_DATA_W-1:0]  cfg_data,
    // body byte requests
    input  logic                            body_valid,
    output logic                            body_ready,
    input  bru_pkg::bru_body_t              body,
    // write record requests
    output logic                            rec_valid,
    input  logic                            rec_ready,
    output bru_pkg::bru_rec_t               rec
);

    bru_pkg::bru_cfg_t  cfg;

    // Input register: holds one body byte request
    logic               in_valid_reg;
    bru_pkg::bru_body_t in_data_reg;

    // Result register: holds one write record request
    logic               rec_valid_reg;
    bru_pkg::bru_rec_t  rec_data_reg;

    logic               advance;
    logic               hit;
    bru_pkg::bru_rec_t  rec_next;

    // The byte in the input register is decoded as soon as the result
    // register is free or being emptied in the same cycle.
    assign advance    = in_valid_reg && (!rec_valid_reg || rec_ready);
    // Input register refills when empty or when its byte moves on.
    assign body_ready = !in_valid_reg || advance;

    bru_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bru_core #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .body  (in_data_reg),
        .cfg   (cfg),
        .hit   (hit),
        .rec   (rec_next)
    );

    // Control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (body_ready)
            begin
                in_valid_reg <= body_valid;
            end
            if (!rec_valid_reg || rec_ready)
            begin
                rec_valid_reg <= advance && hit;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (body_valid && body_ready)
        begin
            in_data_reg <= body;
        end
        if (advance && hit)
        begin
            rec_data_reg <= rec_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_data_reg;

endmodule

// ----- src/bru_checker.sv -----
`include "byterun1_bitplane_unpacker_macros.svh"

module bru_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               body_valid,
    input logic               body_ready,
    input bru_pkg::bru_body_t body,
    input logic               rec_valid,
    input logic               rec_ready,
    input bru_pkg::bru_rec_t  rec
);

    // stalled body request must hold
    `BRU_ASSERT_NEXT(a_body_hold, body_valid && !body_ready, body_valid && $stable(body), "body request changed while stalled")

    // stalled record must hold
    `BRU_ASSERT_NEXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(rec), "record changed while stalled")

    // run lengths are 1..128
    `BRU_ASSERT_NOW(a_count_range, rec_valid, (rec.count != 8'd0) && (rec.count <= 8'd128), "record count out of range")

    // a free or draining output slot never blocks the input side
    `BRU_ASSERT_NOW(a_ready_free, !rec_valid || rec_ready, body_ready, "input stalled with output free")

endmodule

bind byterun1_bitplane_unpacker bru_checker u_bru_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .body_valid (body_valid),
    .body_ready (body_ready),
    .body       (body),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
);
